@@ rtl/nmea_phtg_sentence_parser_core_assert.svh @@
// Assertion macros for the verification file of the PHTG sentence parser (phtg_checker).
// No dependencies; include this header by its bare file name.
`ifndef NMEA_PHTG_SENTENCE_PARSER_CORE_ASSERT_SVH
`define NMEA_PHTG_SENTENCE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication checked at every rising clock edge out of reset.
`define PHTG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked at every rising clock edge out of reset.
`define PHTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/phtg_pkg.sv @@
// Package of the PHTG sentence parser: widths, status codes, parser phases and beat types.
// No dependencies; the core, parser and checker modules import it.
package phtg_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int ACC_WIDTH   = 32;
  localparam int NV_WIDTH    = ACC_WIDTH + 4;
  localparam logic [NV_WIDTH-1:0] NUM_LIMIT = NV_WIDTH'(1) << (VALUE_WIDTH - 1);

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int OUT_DATA_WIDTH = 72;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_PHTG   = 3'd1,
    ST_BAD_CSUM   = 3'd2,
    ST_FEW_FIELDS = 3'd3,
    ST_BAD_NUM    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    NP_START  = 4'b0001,
    NP_SIGN   = 4'b0010,
    NP_DIGITS = 4'b0100,
    NP_DONE   = 4'b1000
  } num_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } phtg_beat_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] auth;
    logic [31:0] warning;
  } phtg_res_t;

endpackage

@@ rtl/nmea_phtg_sentence_parser_core.sv @@
// Top level of the PHTG sentence parser: input register, parser and result register.
// Depends on phtg_pkg and phtg_parser.
// Throughput: one byte per cycle, including back-to-back lines, unless a line-end byte waits on a full result register.
// A line-end beat goes through the input register and then the result register, whose valid flag is m_axis_tvalid.
// A stalled result holds only line-end bytes; the others keep advancing the parser.
// Reset clears the sentence state, stored values and both registers' valid flags.
module nmea_phtg_sentence_parser_core import phtg_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] byte_req
  input  logic                      s_axis_tlast,   // line_end
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata    // [2:0] status, [34:3] auth_value,
                                                    // [66:35] warning_value, [71:67] zero
);

  logic       in_vld_q, in_vld_d;
  phtg_beat_t in_beat_q;
  logic       out_vld_q, out_vld_d;
  phtg_res_t  out_res_q;
  phtg_res_t  res;
  logic       step, out_free, in_take;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && (out_free || !in_beat_q.last);
  assign s_axis_tready = !in_vld_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = in_take || (in_vld_q && !step);
  assign out_vld_d = (step && in_beat_q.last) || (out_vld_q && !m_axis_tready);

  phtg_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_beat_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q.data <= s_axis_tdata;
      in_beat_q.last <= s_axis_tlast;
    end
    if (step && in_beat_q.last) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b00000, out_res_q.warning, out_res_q.auth, out_res_q.status};

endmodule

@@ rtl/phtg_parser.sv @@
// Per-byte sentence state and result logic of the PHTG parser.
// Depends on phtg_pkg; instantiated by nmea_phtg_sentence_parser_core.
module phtg_parser import phtg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  phtg_beat_t beat_i,
  output phtg_res_t  res_o
);

  logic [2:0]  pos_q, pos_d;
  logic        hdr_q, hdr_d;
  logic        star_q, star_d;
  logic [7:0]  xor_q, xor_d;
  logic [1:0]  ckn_q, ckn_d;
  logic [7:0]  rck_q, rck_d;
  logic        ckbad_q, ckbad_d;
  logic [2:0]  fc_q, fc_d;
  logic        fne_q, fne_d;
  logic [ACC_WIDTH-1:0] acc_q, acc_d;
  num_phase_e  ph_q, ph_d;
  logic        neg_q, neg_d;
  logic        nbad_q, nbad_d;
  logic [31:0] pa_q, pa_d;
  logic [31:0] pw_q, pw_d;
  logic [31:0] sa_q, sa_d;
  logic [31:0] sw_q, sw_d;

  function automatic logic [7:0] hdr_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h48;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h47;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] h;
    if (c inside {[8'h30:8'h39]}) begin
      h = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      h = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      h = {1'b0, 4'(c - 8'h57)};
    end else begin
      h = 5'h10;
    end
    return h;
  endfunction

  logic [7:0]          b;
  logic                digit, blank, fin, acc_go, hdr_ok, cs_ok, num_field;
  logic [4:0]          hx;
  logic [NV_WIDTH-1:0] nv, acc_ext;
  logic [31:0]         v;
  status_e             status;

  always_comb begin
    b      = beat_i.data;
    digit  = b inside {[8'h30:8'h39]};
    blank  = b inside {8'h20, [8'h09:8'h0D]};
    hx     = hex_val(b);
    fin    = 1'b0;
    acc_go = 1'b0;
    v      = '0;
    status = ST_OK;
    hdr_ok = 1'b0;
    cs_ok  = 1'b0;
    nv     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + NV_WIDTH'(b[3:0]);

    pos_d = pos_q; hdr_d = hdr_q; star_d = star_q; xor_d = xor_q;
    ckn_d = ckn_q; rck_d = rck_q; ckbad_d = ckbad_q; fc_d = fc_q;
    fne_d = fne_q; acc_d = acc_q; ph_d = ph_q; neg_d = neg_q; nbad_d = nbad_q;
    pa_d = pa_q; pw_d = pw_q; sa_d = sa_q; sw_d = sw_q;

    num_field = (fc_q == 3'd4) || (fc_q == 3'd5);

    if (pos_q < 3'd5 && b != hdr_char(pos_q)) begin
      hdr_d = 1'b0;
    end

    if (!star_q) begin
      if (b == CH_STAR) begin
        star_d = 1'b1;
        fin    = fne_q;
      end else begin
        if (pos_q >= 3'd1) begin
          xor_d = xor_q ^ b;
        end
        if (pos_q >= 3'd6) begin
          if (b == CH_COMMA) begin
            fin = 1'b1;
          end else begin
            fne_d = 1'b1;
            if (num_field) begin
              case (ph_q)
                NP_START: begin
                  if (blank) begin
                    ph_d = NP_START;
                  end else if (b == CH_PLUS || b == CH_MINUS) begin
                    neg_d = (b == CH_MINUS);
                    ph_d  = NP_SIGN;
                  end else if (!digit) begin
                    nbad_d = 1'b1;
                    ph_d   = NP_DONE;
                  end else begin
                    ph_d   = NP_DIGITS;
                    acc_go = 1'b1;
                  end
                end
                NP_SIGN: begin
                  if (!digit) begin
                    nbad_d = 1'b1;
                    ph_d   = NP_DONE;
                  end else begin
                    ph_d   = NP_DIGITS;
                    acc_go = 1'b1;
                  end
                end
                NP_DIGITS: begin
                  if (!digit) begin
                    ph_d = NP_DONE;
                  end else begin
                    acc_go = 1'b1;
                  end
                end
                default: begin
                  ph_d = ph_q;
                end
              endcase
              if (acc_go) begin
                if (nv > NUM_LIMIT) begin
                  nbad_d = 1'b1;
                end else begin
                  acc_d = nv[ACC_WIDTH-1:0];
                end
              end
            end
          end
        end
      end
    end else if (ckn_q < 2'd2) begin
      if (hx[4]) begin
        ckbad_d = 1'b1;
      end
      rck_d = {rck_q[3:0], hx[3:0]};
      ckn_d = ckn_q + 2'd1;
    end

    pos_d = (pos_q < 3'd6) ? pos_q + 3'd1 : 3'd6;

    fin = fin | (beat_i.last && !star_d && fne_d);

    acc_ext = {{(NV_WIDTH-ACC_WIDTH){1'b0}}, acc_d};
    if (fin) begin
      if (num_field) begin
        if (fne_d) begin
          if (ph_d == NP_START || ph_d == NP_SIGN) begin
            nbad_d = 1'b1;
          end else if (!neg_d && acc_ext > NUM_LIMIT - NV_WIDTH'(1)) begin
            nbad_d = 1'b1;
          end
          v = neg_d ? 32'(32'd0 - 32'(acc_d)) : 32'(acc_d);
        end
        if (fc_q == 3'd4) begin
          pa_d = v;
        end else begin
          pw_d = v;
        end
      end
      if (fc_d < 3'd7) begin
        fc_d = fc_d + 3'd1;
      end
      fne_d = 1'b0;
      acc_d = '0;
      ph_d  = NP_START;
      neg_d = 1'b0;
    end

    if (beat_i.last) begin
      hdr_ok = hdr_d && (pos_d >= 3'd5);
      cs_ok  = star_d && (ckn_d == 2'd2) && !ckbad_d && (rck_d == xor_d);
      if (!hdr_ok) begin
        status = ST_NOT_PHTG;
      end else if (!cs_ok) begin
        status = ST_BAD_CSUM;
      end else if (nbad_d) begin
        status = ST_BAD_NUM;
      end else if (fc_d < 3'd6) begin
        status = ST_FEW_FIELDS;
      end else begin
        status = ST_OK;
        sa_d   = pa_d;
        sw_d   = pw_d;
      end
      pos_d = '0; hdr_d = 1'b1; star_d = 1'b0; xor_d = '0; ckn_d = '0;
      rck_d = '0; ckbad_d = 1'b0; fc_d = '0; fne_d = 1'b0; acc_d = '0;
      ph_d = NP_START; neg_d = 1'b0; nbad_d = 1'b0; pa_d = '0; pw_d = '0;
    end

    res_o.status  = status;
    res_o.auth    = sa_d;
    res_o.warning = sw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; hdr_q <= 1'b1; star_q <= 1'b0; xor_q <= '0; ckn_q <= '0;
      rck_q <= '0; ckbad_q <= 1'b0; fc_q <= '0; fne_q <= 1'b0; acc_q <= '0;
      ph_q <= NP_START; neg_q <= 1'b0; nbad_q <= 1'b0; pa_q <= '0; pw_q <= '0;
      sa_q <= '0; sw_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d; hdr_q <= hdr_d; star_q <= star_d; xor_q <= xor_d;
      ckn_q <= ckn_d; rck_q <= rck_d; ckbad_q <= ckbad_d; fc_q <= fc_d;
      fne_q <= fne_d; acc_q <= acc_d; ph_q <= ph_d; neg_q <= neg_d;
      nbad_q <= nbad_d; pa_q <= pa_d; pw_q <= pw_d; sa_q <= sa_d; sw_q <= sw_d;
    end
  end

endmodule

@@ rtl/phtg_checker.sv @@
// Port-level checks of the PHTG sentence parser, bound to its top level.
// Depends on phtg_pkg and nmea_phtg_sentence_parser_core_assert.svh.
`include "nmea_phtg_sentence_parser_core_assert.svh"

module phtg_checker import phtg_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  `PHTG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PHTG_ASSERT_IMPL(a_status_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[2:0] <= ST_BAD_NUM)
  `PHTG_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[71:67] == 5'b00000)
  `PHTG_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule

bind nmea_phtg_sentence_parser_core phtg_checker u_phtg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
